// ----- rtl/wheel_encoder_speed_meter_assert.svh -----
// Assertion macros for the speed meter checker.
// No dependencies; include by bare file name.
`ifndef WHEEL_ENCODER_SPEED_METER_ASSERT_SVH
`define WHEEL_ENCODER_SPEED_METER_ASSERT_SVH

// clocked assertion, masked while reset is asserted
`define WESM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define WESM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/wesm_pkg.sv -----
// Types and constants of the wheel encoder speed meter.
// No dependencies.
package wesm_pkg;

  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned DivSteps  = 36;

  localparam logic [CfgIdxW-1:0] CFG_NOTCH   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 8'd1;

  localparam logic [15:0] NOTCH_RESET   = 16'd1020;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;
  localparam logic [19:0] US_PER_S      = 20'd1000000;
  localparam logic [47:0] DIST_MAX      = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [15:0] notch_distance_um;
    logic [31:0] period_timeout_us;
  } wesm_cfg_t;

  typedef struct packed {
    logic        wheel;
    logic [63:0] timestamp_us;
  } wesm_item_t;

  typedef struct packed {
    logic        start;
    logic [35:0] dividend;
    logic [31:0] divisor;
  } wesm_div_req_t;

  typedef struct packed {
    logic        done;
    logic [35:0] quotient;
  } wesm_div_rsp_t;

endpackage

// ----- rtl/wesm_front.sv -----
// Front end: accepts edge items, drops falling edges, queues rising ones.
// Depends on wesm_pkg.
module wesm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                wheel_side_i,
  input  logic                edge_rising_i,
  input  logic [63:0]         timestamp_us_i,
  output logic                q_valid_o,
  output wesm_pkg::wesm_item_t q_item_o,
  input  logic                q_pop_i
);
  import wesm_pkg::*;

  wesm_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o && edge_rising_i;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{wheel: wheel_side_i, timestamp_us: timestamp_us_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/wesm_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on wesm_pkg.
module wesm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wesm_pkg::wesm_div_req_t req_i,
  output wesm_pkg::wesm_div_rsp_t rsp_o
);
  import wesm_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     rem_q, dvs_q;
  logic [35:0]     quo_q;
  logic [32:0]     trial, diff;
  logic            ge;

  assign trial = {rem_q, quo_q[35]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  assign rsp_o = '{done: done_q, quotient: quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[34:0], ge};
    end
  end

endmodule

// ----- rtl/wesm_back.sv -----
// Back end: per-wheel state update, speed computation and result register.
// Depends on wesm_pkg and wesm_div.
module wesm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wesm_pkg::wesm_cfg_t  cfg_i,
  input  logic                 q_valid_i,
  input  wesm_pkg::wesm_item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 result_wheel_o,
  output logic [31:0]          pulse_total_o,
  output logic [35:0]          speed_um_per_s_o,
  output logic [47:0]          distance_um_o,
  output logic [63:0]          period_us_o
);
  import wesm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} state_e;

  state_e        state_q;
  logic [31:0]   count_q [2];
  logic [63:0]   last_q  [2];
  logic [47:0]   dist_q  [2];
  logic          wheel_q;
  logic [31:0]   pulse_q;
  logic [35:0]   speed_q, prod_q;
  logic [47:0]   dist_out_q;
  logic [63:0]   period_q;
  logic          div_start_q;

  logic          w;
  logic [63:0]   period_d;
  logic [31:0]   count_d;
  logic [48:0]   dist_sum;
  logic [47:0]   dist_d;
  logic          calc;
  wesm_div_req_t div_req;
  wesm_div_rsp_t div_rsp;

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign w        = q_item_i.wheel;
  assign period_d = q_item_i.timestamp_us - last_q[w];
  assign count_d  = count_q[w] + 32'd1;
  assign dist_sum = {1'b0, dist_q[w]} + {33'b0, cfg_i.notch_distance_um};
  assign dist_d   = dist_sum[48] ? DIST_MAX : dist_sum[47:0];
  assign calc     = (period_q != 64'd0) && (period_q < {32'b0, cfg_i.period_timeout_us});

  assign div_req = '{start: div_start_q, dividend: prod_q, divisor: period_q[31:0]};

  wesm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o      = (state_q == ST_OUT);
  assign result_wheel_o   = wheel_q;
  assign pulse_total_o    = pulse_q;
  assign speed_um_per_s_o = speed_q;
  assign distance_um_o    = dist_out_q;
  assign period_us_o      = period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_start_q <= 1'b0;
      count_q[0]  <= '0;
      count_q[1]  <= '0;
      last_q[0]   <= '0;
      last_q[1]   <= '0;
      dist_q[0]   <= '0;
      dist_q[1]   <= '0;
    end else begin
      div_start_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            last_q[w]  <= q_item_i.timestamp_us;
            count_q[w] <= count_d;
            dist_q[w]  <= dist_d;
            state_q    <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (calc) begin
            div_start_q <= 1'b1;
            state_q     <= ST_DIV;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          wheel_q    <= w;
          pulse_q    <= count_d;
          dist_out_q <= dist_d;
          period_q   <= period_d;
          prod_q     <= 36'(cfg_i.notch_distance_um) * 36'(US_PER_S);
        end
      end
      ST_MUL: begin
        if (!calc) speed_q <= '0;
      end
      ST_DIV: begin
        if (div_rsp.done) speed_q <= div_rsp.quotient;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/wheel_encoder_speed_meter.sv -----
// Wheel encoder speed meter: two-wheel period, pulse, distance and speed.
// Depends on wesm_pkg, wesm_front and wesm_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one edge event per item:
//   wheel, edge type and microsecond timestamp. Falling edges are taken
//   and dropped; each rising edge yields one record on the output channel
//   (out_valid_o/out_ready_i): wheel, pulse count, speed, distance, period.
//   Config channel (cfg_valid_i/cfg_ready_o) writes register 0 (notch
//   distance, um) or 1 (period timeout, us); other indexes are ignored.
//   Write config only while no rising edge is in flight.
//   A rising edge passes the queue, then ST_IDLE and ST_MUL in the back end,
//   then ST_DIV, where the 36-step restoring divider runs, and then ST_OUT.
//   With a zero period or one not below the timeout, ST_DIV is skipped and
//   the speed is zero. The back end handles one record at a time.
//   A two-entry queue sits between the accept side and the compute side,
//   so input items are still taken while a record waits for out_ready_i;
//   in_ready_o drops only when the queue is full.
//   Reset clears all per-wheel counters, timestamps and distances and
//   reloads both config registers with their defaults.
module wheel_encoder_speed_meter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wesm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         wheel_side_i,
  input  logic                         edge_rising_i,
  input  logic [63:0]                  timestamp_us_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         result_wheel_o,
  output logic [31:0]                  pulse_total_o,
  output logic [35:0]                  speed_um_per_s_o,
  output logic [47:0]                  distance_um_o,
  output logic [63:0]                  period_us_o
);
  import wesm_pkg::*;

  wesm_cfg_t  cfg_q;
  logic       q_valid, q_pop;
  wesm_item_t q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{notch_distance_um: NOTCH_RESET, period_timeout_us: TIMEOUT_RESET};
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_NOTCH)   cfg_q.notch_distance_um <= cfg_data_i[15:0];
      if (cfg_index_i == CFG_TIMEOUT) cfg_q.period_timeout_us <= cfg_data_i;
    end
  end

  wesm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .wheel_side_i   (wheel_side_i),
    .edge_rising_i  (edge_rising_i),
    .timestamp_us_i (timestamp_us_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  wesm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_wheel_o   (result_wheel_o),
    .pulse_total_o    (pulse_total_o),
    .speed_um_per_s_o (speed_um_per_s_o),
    .distance_um_o    (distance_um_o),
    .period_us_o      (period_us_o)
  );

endmodule

// ----- rtl/wesm_checker.sv -----
// Port-level checker for the wheel encoder speed meter, bound to the top.
// Depends on wheel_encoder_speed_meter_assert.svh and the top level.
`include "wheel_encoder_speed_meter_assert.svh"

module wesm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [35:0] speed_um_per_s_o,
  input logic [47:0] distance_um_o,
  input logic [63:0] period_us_o
);

  `WESM_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(speed_um_per_s_o) &&
    $stable(distance_um_o) && $stable(period_us_o), "result changed while stalled")
  `WESM_ASSERT(a_speed_period, clk_i, rst_ni,
    out_valid_o && speed_um_per_s_o != 36'd0 |->
    period_us_o != 64'd0 && period_us_o[63:32] == 32'd0,
    "nonzero speed with out-of-range period")
  `WESM_ASSERT(a_speed_max, clk_i, rst_ni,
    out_valid_o |-> speed_um_per_s_o <= 36'd65535000000, "speed above notch bound")
  `WESM_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule

bind wheel_encoder_speed_meter wesm_checker u_wesm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .speed_um_per_s_o (speed_um_per_s_o),
  .distance_um_o    (distance_um_o),
  .period_us_o      (period_us_o)
);
